/* hw/rtl/bbsf_pkg.sv */
// Types and codes shared by the bounded byte stream FIFO.
package bbsf_pkg;

  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_PEEK  = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_in;
    logic [9:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             done_res;
    logic             error_flag;
    logic [CAP_W-1:0] fill_level;
    logic [CAP_W-1:0] room_left;
    logic [31:0]      total_written;
    logic [31:0]      total_read;
    logic             closed;
    logic             at_eof;
  } out_item_t;

endpackage

/* hw/rtl/bbsf_mem.sv */
// Byte store with one write port and one registered read port.
module bbsf_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] store_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/bounded_byte_stream_fifo.sv */
// Top level of the bounded byte stream FIFO.
// One item is taken per clock cycle whenever busy is low, and its result
// appears on out_item with out_strobe in the cycle after acceptance, the delay
// of the byte store's registered read port. The receiver cannot stall, so
// each result must be captured in its strobe cycle. A configuration write
// holds busy high for its cycle and is always taken at once. Capacity is
// clipped to DEPTH; bytes already held are kept when it is lowered.
module bounded_byte_stream_fifo
  import bbsf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > CAP_W) ? CW : CAP_W) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [31:0]      wcnt_r, wcnt_nxt;
  logic [31:0]      rcnt_r, rcnt_nxt;
  logic             closed_r, closed_nxt;
  logic             err_r, err_nxt;
  logic [CAP_W-1:0] capacity_r;
  logic             strobe_r;
  logic             hit_r, hit_nxt;
  out_item_t        res_r, res_nxt;

  logic          accept;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign accept    = start && !busy;
  assign busy      = cfg_valid;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [XW-1:0] cap_x;
    logic [XW-1:0] cap_eff;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cnt_new;
    logic [XW-1:0] head_x;
    logic [XW-1:0] tail_sum;
    logic [XW-1:0] peek_sum;
    logic [XW-1:0] head_inc;
    logic [XW-1:0] room_x;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] peek_addr;
    cap_x     = XW'(capacity_r);
    cap_eff   = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
    cnt_x     = XW'(count_r);
    head_x    = XW'(head_r);
    tail_sum  = head_x + cnt_x;
    peek_sum  = head_x + XW'(in_item.offset);
    head_inc  = head_x + XW'(1);
    tail_addr = AW'((tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum);
    peek_addr = AW'((peek_sum >= DEPTH_X) ? peek_sum - DEPTH_X : peek_sum);

    head_nxt   = head_r;
    count_nxt  = count_r;
    wcnt_nxt   = wcnt_r;
    rcnt_nxt   = rcnt_r;
    closed_nxt = closed_r;
    err_nxt    = err_r;
    hit_nxt    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = tail_addr;
    rd_addr    = head_r;

    unique case (in_item.func)
      FUNC_WRITE: begin
        if (cnt_x < cap_eff) begin
          wr_en     = accept;
          count_nxt = count_r + CW'(1);
          wcnt_nxt  = wcnt_r + 32'd1;
          hit_nxt   = 1'b1;
        end
      end
      FUNC_READ: begin
        if (cnt_x != '0) begin
          rd_en     = accept;
          head_nxt  = (head_inc == DEPTH_X) ? '0 : AW'(head_inc);
          count_nxt = count_r - CW'(1);
          rcnt_nxt  = rcnt_r + 32'd1;
          hit_nxt   = 1'b1;
        end else begin
          err_nxt = 1'b1;
        end
      end
      FUNC_PEEK: begin
        rd_addr = peek_addr;
        if (XW'(in_item.offset) < cnt_x) begin
          rd_en   = accept;
          hit_nxt = 1'b1;
        end
      end
      FUNC_END: begin
        closed_nxt = 1'b1;
      end
      default: begin
        closed_nxt = closed_r;
      end
    endcase

    cnt_new = XW'(count_nxt);
    room_x  = (cnt_new < cap_eff) ? cap_eff - cnt_new : '0;

    res_nxt               = '0;
    res_nxt.done_res      = hit_nxt;
    res_nxt.error_flag    = err_nxt;
    res_nxt.fill_level    = CAP_W'(cnt_new);
    res_nxt.room_left     = CAP_W'(room_x);
    res_nxt.total_written = wcnt_nxt;
    res_nxt.total_read    = rcnt_nxt;
    res_nxt.closed        = closed_nxt;
    res_nxt.at_eof        = closed_nxt && (cnt_new == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      wcnt_r     <= '0;
      rcnt_r     <= '0;
      closed_r   <= 1'b0;
      err_r      <= 1'b0;
      capacity_r <= CAP_RESET;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      if (accept) begin
        head_r   <= head_nxt;
        count_r  <= count_nxt;
        wcnt_r   <= wcnt_nxt;
        rcnt_r   <= rcnt_nxt;
        closed_r <= closed_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
      hit_r <= hit_nxt && ((in_item.func == FUNC_READ) || (in_item.func == FUNC_PEEK));
    end
  end

  bbsf_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item.data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_item          = res_r;
    out_item.data_out = hit_r ? rd_data : 8'd0;
  end

  assign out_strobe = strobe_r;

endmodule
